// File: sv/mrde_pkg.sv
package mrde_pkg;

  localparam int unsigned DictEntries = 64;
  localparam int unsigned DictIdxW    = 6;
  localparam int unsigned KeyCount    = 256;
  localparam int unsigned MaxBytes    = 4;

  localparam logic       FuncPixel   = 1'b0;
  localparam logic       FuncDictWr  = 1'b1;

  localparam logic [7:0] TagDiff     = 8'h40;
  localparam logic [7:0] TagDelta    = 8'h80;
  localparam logic [7:0] TagRun      = 8'hC0;
  localparam logic [7:0] EscapeByte  = 8'hFF;
  localparam logic [5:0] RunCap      = 6'd63;

  typedef struct packed {
    logic                func;
    logic [7:0]          pix;
    logic                row_end;
    logic [DictIdxW-1:0] idx;
    logic                dvalid;
  } item_t;

  typedef struct packed {
    logic [2:0]                cnt;
    logic [MaxBytes-1:0][7:0] bytes;
    logic                      row_end;
  } res_t;

  function automatic logic dict_idx_ok(logic [DictIdxW-1:0] idx);
    return 32'(idx) < DictEntries;
  endfunction

endpackage

// File: sv/mrde_dict.sv
module mrde_dict import mrde_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  item_t               item_i,
  output logic                look_vld_o,
  output logic [DictIdxW-1:0] look_idx_o
);

  logic [DictIdxW-1:0] mem [KeyCount];
  logic [KeyCount-1:0] vld_q;
  logic                look_vld_q;
  logic [DictIdxW-1:0] look_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (acc_i && item_i.func == FuncDictWr) begin
      if (!item_i.dvalid) begin
        vld_q[item_i.pix] <= 1'b0;
      end else if (dict_idx_ok(item_i.idx)) begin
        vld_q[item_i.pix] <= 1'b1;
      end
    end
  end

  // Lookup is taken as the pixel enters the input register.
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      if (item_i.func == FuncDictWr) begin
        if (item_i.dvalid && dict_idx_ok(item_i.idx)) begin
          mem[item_i.pix] <= item_i.idx;
        end
      end else begin
        look_idx_q <= mem[item_i.pix];
        look_vld_q <= vld_q[item_i.pix];
      end
    end
  end

  assign look_vld_o = look_vld_q;
  assign look_idx_o = look_idx_q;

endmodule

// File: sv/mrde_enc.sv
module mrde_enc import mrde_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  item_t               item_i,
  input  logic                look_vld_i,
  input  logic [DictIdxW-1:0] look_idx_i,
  output res_t                res_o
);

  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
  } sgl_t;

  logic [7:0]          prev_q, prev_d;
  logic [5:0]          rep_q, rep_d;
  logic [7:0]          held_q, held_d;
  logic                held_v_q, held_v_d;
  logic                started_q, started_d;
  logic                held_ev_q, held_ev_d;
  logic [DictIdxW-1:0] held_ei_q, held_ei_d;

  logic [MaxBytes-1:0][7:0] bytes;
  logic [2:0]               n;
  logic signed [8:0]        d0, d1;
  sgl_t                     sg;

  function automatic logic small_diff(logic signed [8:0] d);
    return (d >= -9'sd4) && (d <= 9'sd3);
  endfunction

  function automatic logic signed [8:0] sdiff(logic [7:0] a, logic [7:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic logic [2:0] bias4(logic signed [8:0] d);
    logic signed [8:0] t;
    t = d + 9'sd4;
    return t[2:0];
  endfunction

  // DELTA, INDEX or escape for one pixel against the given previous value.
  function automatic sgl_t single_code(logic [7:0] v, logic [7:0] pv, logic ev,
                                       logic [DictIdxW-1:0] ei);
    logic signed [8:0] dl;
    logic signed [8:0] t;
    sgl_t              r;
    dl = sdiff(v, pv);
    t  = dl + 9'sd32;
    r  = '0;
    if (dl >= -9'sd32 && dl <= 9'sd31) begin
      r.n  = 2'd1;
      r.b0 = TagDelta | {2'b00, t[5:0]};
    end else if (ev) begin
      r.n  = 2'd1;
      r.b0 = {{(8-DictIdxW){1'b0}}, ei};
    end else begin
      r.n  = 2'd2;
      r.b0 = EscapeByte;
      r.b1 = v;
    end
    return r;
  endfunction

  always_comb begin
    prev_d    = prev_q;
    rep_d     = rep_q;
    held_d    = held_q;
    held_v_d  = held_v_q;
    started_d = started_q;
    held_ev_d = held_ev_q;
    held_ei_d = held_ei_q;
    bytes     = '0;
    n         = 3'd0;
    d0        = sdiff(held_q, prev_q);
    d1        = '0;
    sg        = '0;

    if (item_i.func == FuncDictWr) begin
      // Track map changes for the pending pixel.
      if (held_v_q && item_i.pix == held_q) begin
        if (!item_i.dvalid) begin
          held_ev_d = 1'b0;
        end else if (dict_idx_ok(item_i.idx)) begin
          held_ev_d = 1'b1;
          held_ei_d = item_i.idx;
        end
      end
    end else begin
      if (!started_q) begin
        bytes[n[1:0]] = item_i.pix;
        n             = n + 3'd1;
        prev_d        = item_i.pix;
        rep_d         = '0;
        held_v_d      = 1'b0;
        held_d        = '0;
        started_d     = 1'b1;
      end else if (held_v_q) begin
        d1       = sdiff(item_i.pix, held_q);
        held_v_d = 1'b0;
        held_d   = '0;
        if (small_diff(d0) && small_diff(d1)) begin
          bytes[n[1:0]] = TagDiff | {2'b00, bias4(d0), bias4(d1)};
          n             = n + 3'd1;
          prev_d        = item_i.pix;
        end else begin
          sg = single_code(held_q, prev_q, held_ev_q, held_ei_q);
          bytes[n[1:0]] = sg.b0;
          n             = n + 3'd1;
          if (sg.n == 2'd2) begin
            bytes[n[1:0]] = sg.b1;
            n             = n + 3'd1;
          end
          prev_d = held_q;
          if (item_i.pix == prev_d) begin
            rep_d = 6'd1;
          end else begin
            held_d    = item_i.pix;
            held_v_d  = 1'b1;
            held_ev_d = look_vld_i;
            held_ei_d = look_idx_i;
          end
        end
      end else if (rep_q != '0) begin
        d1 = sdiff(item_i.pix, prev_q);
        if (item_i.pix == prev_q) begin
          rep_d = rep_q + 6'd1;
          if (rep_d == RunCap) begin
            bytes[n[1:0]] = TagRun | {2'b00, RunCap - 6'd1};
            n             = n + 3'd1;
            rep_d         = '0;
          end
        end else begin
          rep_d = '0;
          if (rep_q >= 6'd2) begin
            bytes[n[1:0]] = TagRun | {2'b00, rep_q - 6'd1};
            n             = n + 3'd1;
          end else if (small_diff(d1)) begin
            bytes[n[1:0]] = TagDiff | {2'b00, 3'd4, bias4(d1)};
            n             = n + 3'd1;
            prev_d        = item_i.pix;
          end else begin
            bytes[n[1:0]] = TagRun;
            n             = n + 3'd1;
          end
          if (!(rep_q < 6'd2 && small_diff(d1))) begin
            // pixel differs from previous here, so it always becomes pending
            held_d    = item_i.pix;
            held_v_d  = 1'b1;
            held_ev_d = look_vld_i;
            held_ei_d = look_idx_i;
          end
        end
      end else begin
        if (item_i.pix == prev_q) begin
          rep_d = 6'd1;
        end else begin
          held_d    = item_i.pix;
          held_v_d  = 1'b1;
          held_ev_d = look_vld_i;
          held_ei_d = look_idx_i;
        end
      end

      // Flush everything pending at the end of the row.
      if (item_i.row_end) begin
        if (rep_d >= 6'd2) begin
          bytes[n[1:0]] = TagRun | {2'b00, rep_d - 6'd1};
          n             = n + 3'd1;
        end else if (rep_d == 6'd1) begin
          bytes[n[1:0]] = TagRun;
          n             = n + 3'd1;
        end
        if (held_v_d) begin
          sg = single_code(held_d, prev_d, held_ev_d, held_ei_d);
          bytes[n[1:0]] = sg.b0;
          n             = n + 3'd1;
          if (sg.n == 2'd2) begin
            bytes[n[1:0]] = sg.b1;
            n             = n + 3'd1;
          end
          prev_d = held_d;
        end
        rep_d     = '0;
        held_v_d  = 1'b0;
        held_d    = '0;
        started_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      rep_q     <= '0;
      held_q    <= '0;
      held_v_q  <= 1'b0;
      started_q <= 1'b0;
      held_ev_q <= 1'b0;
      held_ei_q <= '0;
    end else if (fire_i) begin
      prev_q    <= prev_d;
      rep_q     <= rep_d;
      held_q    <= held_d;
      held_v_q  <= held_v_d;
      started_q <= started_d;
      held_ev_q <= held_ev_d;
      held_ei_q <= held_ei_d;
    end
  end

  assign res_o.cnt     = n;
  assign res_o.bytes   = bytes;
  assign res_o.row_end = item_i.row_end;

endmodule

// File: sv/mrde_obuf.sv
module mrde_obuf import mrde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  res_t       res_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       row_last_o
);

  logic [MaxBytes-1:0][7:0] bytes_q;
  logic [2:0]               rem_q;
  logic                     row_end_q;
  logic                     pop;

  assign out_valid_o = rem_q != 3'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign free_o      = (rem_q == 3'd0) || (rem_q == 3'd1 && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (load_i) begin
      rem_q <= res_i.cnt;
    end else if (pop) begin
      rem_q <= rem_q - 3'd1;
    end
  end

  // Advance the byte queue by one position on each transaction.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q   <= res_i.bytes;
      row_end_q <= res_i.row_end;
    end else if (pop) begin
      bytes_q <= {8'h00, bytes_q[MaxBytes-1:1]};
    end
  end

  assign out_byte_o = bytes_q[0];
  assign last_o     = rem_q == 3'd1;
  assign row_last_o = (rem_q == 3'd1) && row_end_q;

endmodule

// File: sv/mask_row_run_diff_encoder_core.sv
// Row encoder for quantized single-channel pixels: each pixel transaction
// (func = 0) yields zero to four bytes of a QOI-style code (raw first byte,
// RUN, DIFF, DELTA, INDEX, 0xFF escape); each dictionary transaction
// (func = 1) updates one entry of a 256-key map and yields nothing. An item
// passes the input register; its bytes then leave one per cycle through the
// output port while out_ready_i is high, bound by the single-byte output
// channel. The map is a 256 x 6 memory with per-key valid flops cleared by
// reset, so no clearing pass is needed.
module mask_row_run_diff_encoder_core import mrde_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic [7:0]          pixel_value_i,
  input  logic                row_end_i,
  input  logic [DictIdxW-1:0] dict_index_i,
  input  logic                dict_valid_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                last_of_run_o,
  output logic                row_last_byte_o
);

  item_t               item_in;
  item_t               item_q;
  logic                s1_valid_q;
  logic                s1_fire;
  logic                accept;
  logic                look_vld;
  logic [DictIdxW-1:0] look_idx;
  res_t                res;
  logic                obuf_free;

  assign item_in.func    = func_i;
  assign item_in.pix     = pixel_value_i;
  assign item_in.row_end = row_end_i;
  assign item_in.idx     = dict_index_i;
  assign item_in.dvalid  = dict_valid_i;

  // Items with no bytes never wait for the output side.
  assign s1_fire    = s1_valid_q && ((res.cnt == 3'd0) || obuf_free);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_in;
    end
  end

  mrde_dict u_dict (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (accept),
    .item_i     (item_in),
    .look_vld_o (look_vld),
    .look_idx_o (look_idx)
  );

  mrde_enc u_enc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (s1_fire),
    .item_i     (item_q),
    .look_vld_i (look_vld),
    .look_idx_i (look_idx),
    .res_o      (res)
  );

  mrde_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_fire && (res.cnt != 3'd0)),
    .res_i       (res),
    .free_o      (obuf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_of_run_o),
    .row_last_o  (row_last_byte_o)
  );

endmodule

// File: tb/mask_row_run_diff_encoder_core_tb.sv
module mask_row_run_diff_encoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrde_pkg::*;

  localparam int DeltaLow      = -32;
  localparam int DeltaHigh     = 31;
  localparam int DiffLow       = -4;
  localparam int DiffHigh      = 3;
  localparam int IdlePct       = 38;
  localparam int WatchdogLimit = 2000;
  localparam int RandomItems   = 150;
  localparam int DrainCycles   = 20;

  typedef struct {
    logic [7:0] data;
    logic       item_last;
    logic       row_last;
  } code_byte_t;

  // Row code predictor plus the queue of bytes it still owes.
  class RowCodeScoreboard;
    logic [7:0]          prev_pix;
    int                  run_len;
    logic [7:0]          held_pix;
    bit                  held_vld;
    bit                  in_row;
    bit                  dict_hit [KeyCount];
    logic [DictIdxW-1:0] dict_idx [KeyCount];
    logic [7:0]          item_bytes[$];
    code_byte_t          pending_bytes[$];
    int                  errors;

    function new();
      prev_pix = '0;
      run_len  = 0;
      held_pix = '0;
      held_vld = 1'b0;
      in_row   = 1'b0;
      errors   = 0;
      foreach (dict_hit[k]) begin
        dict_hit[k] = 1'b0;
        dict_idx[k] = '0;
      end
    endfunction

    function bit small_step(int d);
      return d >= DiffLow && d <= DiffHigh;
    endfunction

    // Code one pixel on its own: DELTA, then INDEX, else escape plus value.
    function void code_single(logic [7:0] v);
      int d;
      d = int'(v) - int'(prev_pix);
      if (d >= DeltaLow && d <= DeltaHigh) begin
        item_bytes.push_back(TagDelta | 8'(d - DeltaLow));
      end else if (dict_hit[v]) begin
        item_bytes.push_back(8'(dict_idx[v]));
      end else begin
        item_bytes.push_back(EscapeByte);
        item_bytes.push_back(v);
      end
      prev_pix = v;
    endfunction

    function void park(logic [7:0] p);
      if (p == prev_pix) begin
        run_len = 1;
      end else begin
        held_pix = p;
        held_vld = 1'b1;
      end
    endfunction

    function void note_item(logic f, logic [7:0] p, logic re, logic [DictIdxW-1:0] ix,
                            logic dv);
      int         d0;
      int         d1;
      int         n;
      int         k;
      logic [7:0] h;
      if (f == FuncDictWr) begin
        if (!dv) begin
          dict_hit[p] = 1'b0;
        end else if (32'(ix) < DictEntries) begin
          dict_hit[p] = 1'b1;
          dict_idx[p] = ix;
        end
        return;
      end
      item_bytes.delete();
      if (!in_row) begin
        item_bytes.push_back(p);
        prev_pix = p;
        run_len  = 0;
        held_vld = 1'b0;
        held_pix = '0;
        in_row   = 1'b1;
      end else if (held_vld) begin
        d0 = int'(held_pix) - int'(prev_pix);
        d1 = int'(p) - int'(held_pix);
        h = held_pix;
        held_vld = 1'b0;
        held_pix = '0;
        if (small_step(d0) && small_step(d1)) begin
          item_bytes.push_back(TagDiff | 8'((d0 + 4) << 3) | 8'(d1 + 4));
          prev_pix = p;
        end else begin
          code_single(h);
          park(p);
        end
      end else if (run_len > 0) begin
        if (p == prev_pix) begin
          run_len++;
          if (run_len >= int'(RunCap)) begin
            item_bytes.push_back(TagRun | 8'(int'(RunCap) - 1));
            run_len = 0;
          end
        end else if (run_len >= 2) begin
          item_bytes.push_back(TagRun | 8'(run_len - 1));
          run_len = 0;
          park(p);
        end else begin
          // lone repeat: pair it into DIFF with zero first step if possible
          d1 = int'(p) - int'(prev_pix);
          run_len = 0;
          if (small_step(d1)) begin
            item_bytes.push_back(TagDiff | 8'(4 << 3) | 8'(d1 + 4));
            prev_pix = p;
          end else begin
            item_bytes.push_back(TagRun);
            park(p);
          end
        end
      end else begin
        park(p);
      end
      // flush whatever is still deferred at the end of the row
      if (re) begin
        if (run_len >= 2) begin
          item_bytes.push_back(TagRun | 8'(run_len - 1));
        end else if (run_len == 1) begin
          item_bytes.push_back(TagRun);
        end
        if (held_vld) begin
          code_single(held_pix);
        end
        run_len  = 0;
        held_vld = 1'b0;
        held_pix = '0;
        in_row   = 1'b0;
      end
      n = item_bytes.size();
      for (k = 0; k < n && k < int'(MaxBytes); k++) begin
        pending_bytes.push_back('{item_bytes[k], k == n - 1, (k == n - 1) && re});
      end
    endfunction

    function void check_byte(logic [7:0] data, logic il, logic rl);
      code_byte_t want;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte %02h last_of_run %0b row_last_byte %0b",
                 $time, data, il, rl);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      if (data !== want.data) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
        errors++;
      end
      if (il !== want.item_last) begin
        $display("%0t: last_of_run expected %0b actual %0b", $time, want.item_last, il);
        errors++;
      end
      if (rl !== want.row_last) begin
        $display("%0t: row_last_byte expected %0b actual %0b", $time, want.row_last, rl);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                func_i;
  logic [7:0]          pixel_value_i;
  logic                row_end_i;
  logic [DictIdxW-1:0] dict_index_i;
  logic                dict_valid_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [7:0]          out_byte_o;
  logic                last_of_run_o;
  logic                row_last_byte_o;

  RowCodeScoreboard book;
  bit               no_idle;
  int               sent_items;
  int               stall_cycles;
  logic [7:0]       cur_pix;
  logic [7:0]       key_pool [4];

  mask_row_run_diff_encoder_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .pixel_value_i  (pixel_value_i),
    .row_end_i      (row_end_i),
    .dict_index_i   (dict_index_i),
    .dict_valid_i   (dict_valid_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .row_last_byte_o(row_last_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Drive the output stall, record accepted transactions, check bytes, watchdog.
  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(99) >= IdlePct);
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        book.note_item(func_i, pixel_value_i, row_end_i, dict_index_i, dict_valid_i);
      end
      if (out_valid_o && out_ready_i) begin
        book.check_byte(out_byte_o, last_of_run_o, row_last_byte_o);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, WatchdogLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(logic f, logic [7:0] p, logic re, logic [DictIdxW-1:0] ix,
                           logic dv);
    if (!no_idle && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < IdlePct) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    pixel_value_i <= p;
    row_end_i     <= re;
    dict_index_i  <= ix;
    dict_valid_i  <= dv;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_items++;
  endtask

  task automatic send_pixel(logic [7:0] p, logic re);
    send_item(FuncPixel, p, re, DictIdxW'($urandom), 1'($urandom));
  endtask

  task automatic send_dict(logic [7:0] key, logic [DictIdxW-1:0] ix, logic dv);
    send_item(FuncDictWr, key, 1'($urandom), ix, dv);
  endtask

  // Mostly runs, small steps and dictionary keys, with some far jumps and
  // dictionary updates mixed in.
  task automatic random_row(int len, int streak);
    int         i;
    int         pick;
    logic [7:0] nxt;
    logic [7:0] key;
    logic       dv;
    for (i = 0; i < len; i++) begin
      if (streak > 0) begin
        nxt = cur_pix;
        streak--;
      end else begin
        pick = $urandom_range(99);
        if (pick < 25) nxt = cur_pix;
        else if (pick < 50) nxt = cur_pix + 8'($urandom_range(7)) - 8'd4;
        else if (pick < 65) nxt = cur_pix + 8'($urandom_range(63)) - 8'd32;
        else if (pick < 78) nxt = key_pool[$urandom_range(3)];
        else nxt = 8'($urandom);
        if ($urandom_range(99) < 8) streak = $urandom_range(2, 8);
      end
      if ($urandom_range(99) < 8) begin
        key = $urandom_range(1) ? 8'($urandom) : key_pool[$urandom_range(3)];
        dv  = ($urandom_range(3) != 0);
        if (dv) key_pool[$urandom_range(3)] = key;
        send_dict(key, DictIdxW'($urandom), dv);
      end
      no_idle = (sent_items >= 90 && sent_items < 150);
      send_pixel(nxt, i == len - 1);
      cur_pix = nxt;
    end
  endtask

  initial begin
    int rows;
    int run_streak;
    book = new();
    no_idle       = 1'b0;
    sent_items    = 0;
    stall_cycles  = 0;
    cur_pix       = '0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    func_i        <= FuncPixel;
    pixel_value_i <= '0;
    row_end_i     <= 1'b0;
    dict_index_i  <= '0;
    dict_valid_i  <= 1'b0;
    out_ready_i   <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // dictionary: both index extremes, then remove one key again
    send_dict(8'hA5, 6'h3F, 1'b1);
    send_dict(8'h00, 6'h00, 1'b1);
    send_dict(8'h5A, 6'h15, 1'b1);
    send_dict(8'h5A, 6'h2A, 1'b0);
    // single-pixel row
    send_pixel(8'hFF, 1'b1);
    // raw, index, escape, run, diff, lone repeat, delta, escape at row end
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hA5, 1'b0);
    send_pixel(8'h5A, 1'b0);
    send_pixel(8'h5A, 1'b0);
    send_pixel(8'h5A, 1'b0);
    send_pixel(8'h5A, 1'b0);
    send_pixel(8'h5B, 1'b0);
    send_pixel(8'h5D, 1'b0);
    send_pixel(8'h5D, 1'b0);
    send_pixel(8'h70, 1'b0);
    send_pixel(8'h90, 1'b1);
    // lone repeat paired into DIFF
    send_pixel(8'h20, 1'b0);
    send_pixel(8'h20, 1'b0);
    send_pixel(8'h21, 1'b1);
    // lone repeat pending at row end
    send_pixel(8'h30, 1'b0);
    send_pixel(8'h30, 1'b1);
    // index zero, then escape at row end
    send_pixel(8'hF0, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hF0, 1'b1);

    key_pool[0] = 8'hA5;
    key_pool[1] = 8'h00;
    key_pool[2] = 8'h5A;
    key_pool[3] = 8'hA5;
    cur_pix     = 8'hF0;
    rows        = 0;
    sent_items  = 0;
    while (sent_items < RandomItems) begin
      // a couple of rows open with a long run that can reach the cap
      if (rows == 1 || rows == 4) begin
        run_streak = $urandom_range(62, 70);
        random_row(run_streak + $urandom_range(1, 5), run_streak);
      end else begin
        random_row($urandom_range(1, 16), 0);
      end
      rows++;
    end
    in_valid_i <= 1'b0;
    no_idle = 1'b0;

    @(posedge clk_i);
    while (book.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (book.errors == 0 && book.pending_bytes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
